// ===== hw/rtl/pms_pkg.sv =====
// ----------------------------------------------------------------------------
// Polyline miter stroker package
// Shared widths, configuration register indexes and the command and pair
// types that pass between the sequencer, the root/divide unit and the
// output stage.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int COORD_W   = 24;
  localparam int THICK_W   = 16;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_THICKNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR     = 1'b1;

  localparam int OFS_W = 22;

  localparam int SD_BITS_W = 64;
  localparam int SD_REM_W  = 32;
  localparam int SD_DEN_W  = 32;
  localparam int SD_CNT_W  = 6;
  localparam int SD_RES_W  = 40;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } sd_op_e;

  typedef struct packed {
    sd_op_e                op;
    logic [SD_BITS_W-1:0]  bits;
    logic [SD_REM_W-1:0]   rem;
    logic [SD_DEN_W-1:0]   den;
    logic [SD_CNT_W-1:0]   count;
  } sd_cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [OFS_W-1:0]   ox;
    logic signed [OFS_W-1:0]   oy;
    logic                      last;
  } pair_t;

endpackage

// ===== hw/rtl/pms_sqdiv.sv =====
// ----------------------------------------------------------------------------
// Shared root/divide unit
// Restoring integer square root (two radicand bits per cycle) and restoring
// division (one quotient bit per cycle) in one set of shift registers.
// ----------------------------------------------------------------------------
module pms_sqdiv import pms_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  sd_cmd_t             cmd_i,
  output logic                done_o,
  output logic [SD_RES_W-1:0] res_o
);

  localparam int REM_W = SD_REM_W + 3;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  sd_op_e               op_q, op_d;
  logic [SD_BITS_W-1:0] bits_q, bits_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [SD_DEN_W-1:0]  den_q, den_d;
  logic [SD_RES_W-1:0]  res_q, res_d;
  logic [SD_CNT_W-1:0]  cnt_q, cnt_d;

  logic [REM_W-1:0] cand, trial;
  logic             take;

  always_comb begin
    if (op_q == OP_SQRT) begin
      cand  = {rem_q[REM_W-3:0], bits_q[SD_BITS_W-1 -: 2]};
      trial = {1'b0, res_q[SD_REM_W-1:0], 2'b01};
    end else begin
      cand  = {rem_q[REM_W-2:0], bits_q[SD_BITS_W-1]};
      trial = REM_W'(den_q);
    end
    take = (cand >= trial);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    bits_d = bits_q;
    rem_d  = rem_q;
    den_d  = den_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      bits_d = cmd_i.bits;
      rem_d  = REM_W'(cmd_i.rem);
      den_d  = cmd_i.den;
      res_d  = '0;
      cnt_d  = cmd_i.count;
    end else if (busy_q) begin
      rem_d  = take ? (cand - trial) : cand;
      res_d  = {res_q[SD_RES_W-2:0], take};
      bits_d = (op_q == OP_SQRT) ? (bits_q << 2) : (bits_q << 1);
      cnt_d  = cnt_q - SD_CNT_W'(1);
      if (cnt_q == SD_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    bits_q <= bits_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    res_q  <= res_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hw/rtl/pms_emit.sv =====
// ----------------------------------------------------------------------------
// Vertex pair output stage
// Adds and subtracts the offset from the base point, saturates each
// coordinate and holds the pair in an output register until its transfer.
// ----------------------------------------------------------------------------
module pms_emit import pms_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  pair_t                     pair_i,
  input  logic [COLOR_W-1:0]        color_i,
  output logic                      rdy_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] left_x_o,
  output logic signed [COORD_W-1:0] left_y_o,
  output logic signed [COORD_W-1:0] right_x_o,
  output logic signed [COORD_W-1:0] right_y_o,
  output logic [COLOR_W-1:0]        pair_color_o,
  output logic                      clipped_o,
  output logic                      strip_end_o
);

  localparam int SUM_W = COORD_W + 2;
  localparam logic signed [SUM_W-1:0] HI =
    {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] LO =
    {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  function automatic logic [COORD_W:0] sat(input logic signed [SUM_W-1:0] v);
    logic [COORD_W:0] r;
    if (v > HI) begin
      r = {1'b1, HI[COORD_W-1:0]};
    end else if (v < LO) begin
      r = {1'b1, LO[COORD_W-1:0]};
    end else begin
      r = {1'b0, v[COORD_W-1:0]};
    end
    return r;
  endfunction

  logic signed [SUM_W-1:0] bx, by, ox, oy;
  logic [COORD_W:0]        lx, ly, rx, ry;

  logic                      vld_q, vld_d;
  logic signed [COORD_W-1:0] lx_q, ly_q, rx_q, ry_q;
  logic [COLOR_W-1:0]        color_q;
  logic                      clip_q, end_q;

  always_comb begin
    bx = SUM_W'(pair_i.px);
    by = SUM_W'(pair_i.py);
    ox = SUM_W'(pair_i.ox);
    oy = SUM_W'(pair_i.oy);
    lx = sat(bx - ox);
    ly = sat(by - oy);
    rx = sat(bx + ox);
    ry = sat(by + oy);
  end

  assign rdy_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lx_q    <= lx[COORD_W-1:0];
      ly_q    <= ly[COORD_W-1:0];
      rx_q    <= rx[COORD_W-1:0];
      ry_q    <= ry[COORD_W-1:0];
      color_q <= color_i;
      clip_q  <= lx[COORD_W] | ly[COORD_W] | rx[COORD_W] | ry[COORD_W];
      end_q   <= pair_i.last;
    end
  end

  assign out_valid_o  = vld_q;
  assign left_x_o     = lx_q;
  assign left_y_o     = ly_q;
  assign right_x_o    = rx_q;
  assign right_y_o    = ry_q;
  assign pair_color_o = color_q;
  assign clipped_o    = clip_q;
  assign strip_end_o  = end_q;

endmodule

// ===== hw/rtl/polyline_miter_stroker.sv =====
// ----------------------------------------------------------------------------
// Polyline miter stroker
// A first point gives no pair. Each later point needs the unit direction of its
// segment (root, then two divides); an interior pair also needs the unit miter
// direction, a ratio divide and a root. Normalization shifts and zero vectors change
// how long this takes. A final point then offers its own end pair through the offset
// steps alone. The input stalls while the sequencer is busy, paced by the shared
// root/divide unit (32 root steps, 18 or 40 quotient steps). Reset clears the
// sequencer, point count and output valid, loads thickness 1.0 and color all ones.
// ----------------------------------------------------------------------------
module polyline_miter_stroker import pms_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic                      final_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] left_x_o,
  output logic signed [COORD_W-1:0] left_y_o,
  output logic signed [COORD_W-1:0] right_x_o,
  output logic signed [COORD_W-1:0] right_y_o,
  output logic [COLOR_W-1:0]        pair_color_o,
  output logic                      clipped_o,
  output logic                      strip_end_o
);

  localparam int VEC_W   = COORD_W + 1;
  localparam int DIR_W   = 19;
  localparam int Q_W     = 18;
  localparam int RAT_W   = 18;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 22;
  localparam int MUL_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 45;

  localparam int DIR_ONE   = 65536;
  localparam int DOT_LIM   = 64881;
  localparam int RATIO_CAP = 163840;

  localparam logic [SD_CNT_W-1:0] SQRT_STEPS = SD_CNT_W'(32);
  localparam logic [SD_CNT_W-1:0] UDIV_STEPS = SD_CNT_W'(Q_W);
  localparam logic [SD_CNT_W-1:0] RDIV_STEPS = SD_CNT_W'(40);
  localparam logic [SD_REM_W-1:0] RDIV_REM0  = SD_REM_W'(512);

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_ABS  = 21'h000002,
    S_NORM = 21'h000004,
    S_SQ1  = 21'h000008,
    S_SQ2  = 21'h000010,
    S_SQ3  = 21'h000020,
    S_ROOT = 21'h000040,
    S_DIVX = 21'h000080,
    S_DIVY = 21'h000100,
    S_URET = 21'h000200,
    S_DOT1 = 21'h000400,
    S_DOT2 = 21'h000800,
    S_DOT3 = 21'h001000,
    S_RDIV = 21'h002000,
    S_RSQ  = 21'h004000,
    S_E1   = 21'h008000,
    S_E2   = 21'h010000,
    S_E3   = 21'h020000,
    S_E4   = 21'h040000,
    S_E5   = 21'h080000,
    S_PUSH = 21'h100000
  } state_e;

  typedef enum logic {
    RET_D2    = 1'b0,
    RET_MITER = 1'b1
  } ret_e;

  function automatic sd_cmd_t unit_div(input logic [VEC_W-1:0] a,
                                       input logic [SD_DEN_W-1:0] l);
    logic [47:0] num;
    sd_cmd_t     c;
    num     = {a[20:0], 26'd0} + {17'd0, l[SD_DEN_W-1:1]};
    c.op    = OP_DIV;
    c.bits  = {num[Q_W-1:0], {(SD_BITS_W-Q_W){1'b0}}};
    c.rem   = SD_REM_W'(num[47:Q_W]);
    c.den   = l;
    c.count = UDIV_STEPS;
    return c;
  endfunction

  function automatic logic signed [OFS_W-1:0] rnd_ofs(input logic signed [MUL_W-1:0] v);
    logic [MUL_W-1:0] mag;
    logic [MUL_W-1:0] r;
    mag = v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
    r   = (mag + (MUL_W'(1) << 32)) >> 33;
    return v[MUL_W-1] ? OFS_W'(MUL_W'(0) - r) : OFS_W'(r);
  endfunction

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic [1:0]         seen_q, seen_d;
  logic [THICK_W-1:0] thick_q, thick_d;
  logic [COLOR_W-1:0] color_q, color_d;

  logic signed [COORD_W-1:0] px_q, px_d, py_q, py_d, held_x_q, held_x_d, held_y_q, held_y_d;
  logic signed [COORD_W-1:0] bx_q, bx_d, by_q, by_d;
  logic                      fin_q, fin_d, last_q, last_d;
  logic signed [DIR_W-1:0]   d1x_q, d1x_d, d1y_q, d1y_d, d2x_q, d2x_d, d2y_q, d2y_d;
  logic signed [DIR_W-1:0]   ux_q, ux_d, uy_q, uy_d, nx_q, nx_d, ny_q, ny_d;
  logic signed [VEC_W-1:0]   vx_q, vx_d, vy_q, vy_d;
  logic [VEC_W-1:0]          ax_q, ax_d, ay_q, ay_d;
  logic                      sx_q, sx_d, sy_q, sy_d;
  logic [SD_DEN_W-1:0]       len_q, len_d;
  logic [Q_W-1:0]            qx_q, qx_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [MUL_W-1:0]   mul_q;
  logic [RAT_W-1:0]          ratio_q, ratio_d;
  logic signed [OFS_W-1:0]   ox_q, ox_d, oy_q, oy_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [VEC_W-1:0]          nrm_max;
  logic signed [ACC_W-1:0]   sum;
  logic [ACC_W-1:0]          dmag, dr;
  logic [16:0]               dclamp;
  logic [16:0]               dden;

  logic                sd_start, sd_done;
  sd_cmd_t             sd_cmd;
  logic [SD_RES_W-1:0] sd_res;
  logic                emit_load, emit_rdy;
  pair_t               emit_pair;

  assign in_stall_o = (state_q != S_IDLE);
  assign nrm_max    = (ax_q > ay_q) ? ax_q : ay_q;
  assign sum        = acc_q + mul_q[ACC_W-1:0];

  always_comb begin
    dmag   = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
    dr     = (dmag + ACC_W'(32768)) >> 16;
    dclamp = (dr > ACC_W'(DOT_LIM)) ? 17'(DOT_LIM) : dr[16:0];
    dden   = sum[ACC_W-1] ? (17'(DIR_ONE) - dclamp) : (17'(DIR_ONE) + dclamp);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ1: begin
        mul_a = MUL_A_W'(ax_q);
        mul_b = MUL_B_W'(ax_q);
      end
      S_SQ2: begin
        mul_a = MUL_A_W'(ay_q);
        mul_b = MUL_B_W'(ay_q);
      end
      S_DOT1: begin
        mul_a = MUL_A_W'(d1x_q);
        mul_b = MUL_B_W'(d2x_q);
      end
      S_DOT2: begin
        mul_a = MUL_A_W'(d1y_q);
        mul_b = MUL_B_W'(d2y_q);
      end
      S_E1: begin
        mul_a = MUL_A_W'(nx_q);
        mul_b = MUL_B_W'(ratio_q);
      end
      S_E3: begin
        mul_a = MUL_A_W'(ny_q);
        mul_b = MUL_B_W'(ratio_q);
      end
      S_E2, S_E4: begin
        mul_a = mul_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(thick_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    seen_d   = seen_q;
    thick_d  = thick_q;
    color_d  = color_q;
    px_d     = px_q;
    py_d     = py_q;
    fin_d    = fin_q;
    held_x_d = held_x_q;
    held_y_d = held_y_q;
    bx_d     = bx_q;
    by_d     = by_q;
    last_d   = last_q;
    d1x_d    = d1x_q;
    d1y_d    = d1y_q;
    d2x_d    = d2x_q;
    d2y_d    = d2y_q;
    ux_d     = ux_q;
    uy_d     = uy_q;
    nx_d     = nx_q;
    ny_d     = ny_q;
    vx_d     = vx_q;
    vy_d     = vy_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    len_d    = len_q;
    qx_d     = qx_q;
    acc_d    = acc_q;
    ratio_d  = ratio_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    sd_start = 1'b0;
    sd_cmd   = '0;
    emit_load = 1'b0;

    if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        REG_THICKNESS: thick_d = cfg_wdata_i[THICK_W-1:0];
        REG_COLOR:     color_d = cfg_wdata_i[COLOR_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          px_d  = point_x_i;
          py_d  = point_y_i;
          fin_d = final_point_i;
          if (seen_q == 2'd0) begin
            if (!final_point_i) begin
              held_x_d = point_x_i;
              held_y_d = point_y_i;
              seen_d   = 2'd1;
            end
          end else begin
            vx_d    = VEC_W'(point_x_i) - VEC_W'(held_x_q);
            vy_d    = VEC_W'(point_y_i) - VEC_W'(held_y_q);
            ret_d   = RET_D2;
            state_d = S_ABS;
          end
        end
      end
      S_ABS: begin
        sx_d = vx_q[VEC_W-1];
        sy_d = vy_q[VEC_W-1];
        ax_d = vx_q[VEC_W-1] ? VEC_W'(-vx_q) : VEC_W'(vx_q);
        ay_d = vy_q[VEC_W-1] ? VEC_W'(-vy_q) : VEC_W'(vy_q);
        if (vx_q == '0 && vy_q == '0) begin
          ux_d    = '0;
          uy_d    = '0;
          state_d = S_URET;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (nrm_max[VEC_W-1:21] != '0) begin
          ax_d = ax_q >> 1;
          ay_d = ay_q >> 1;
        end else if (!nrm_max[20]) begin
          ax_d = ax_q << 1;
          ay_d = ay_q << 1;
        end else begin
          state_d = S_SQ1;
        end
      end
      S_SQ1: state_d = S_SQ2;
      S_SQ2: begin
        acc_d   = mul_q[ACC_W-1:0];
        state_d = S_SQ3;
      end
      S_SQ3: begin
        sd_start     = 1'b1;
        sd_cmd.op    = OP_SQRT;
        sd_cmd.bits  = {sum[43:0], 20'd0};
        sd_cmd.count = SQRT_STEPS;
        state_d      = S_ROOT;
      end
      S_ROOT: begin
        if (sd_done) begin
          len_d    = sd_res[SD_DEN_W-1:0];
          sd_start = 1'b1;
          sd_cmd   = unit_div(ax_q, sd_res[SD_DEN_W-1:0]);
          state_d  = S_DIVX;
        end
      end
      S_DIVX: begin
        if (sd_done) begin
          qx_d     = sd_res[Q_W-1:0];
          sd_start = 1'b1;
          sd_cmd   = unit_div(ay_q, len_q);
          state_d  = S_DIVY;
        end
      end
      S_DIVY: begin
        if (sd_done) begin
          ux_d    = sx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
          uy_d    = sy_q ? -$signed({1'b0, sd_res[Q_W-1:0]})
                         : $signed({1'b0, sd_res[Q_W-1:0]});
          state_d = S_URET;
        end
      end
      S_URET: begin
        if (ret_q == RET_D2) begin
          d2x_d  = ux_q;
          d2y_d  = uy_q;
          bx_d   = held_x_q;
          by_d   = held_y_q;
          last_d = 1'b0;
          if (seen_q == 2'd1) begin
            nx_d    = -uy_q;
            ny_d    = ux_q;
            ratio_d = RAT_W'(DIR_ONE);
            state_d = S_E1;
          end else begin
            vx_d    = -(VEC_W'(d1y_q) + VEC_W'(uy_q));
            vy_d    = VEC_W'(d1x_q) + VEC_W'(ux_q);
            ret_d   = RET_MITER;
            state_d = S_ABS;
          end
        end else begin
          if (ux_q == '0 && uy_q == '0) begin
            nx_d = -d1y_q;
            ny_d = d1x_q;
          end else begin
            nx_d = ux_q;
            ny_d = uy_q;
          end
          state_d = S_DOT1;
        end
      end
      S_DOT1: state_d = S_DOT2;
      S_DOT2: begin
        acc_d   = mul_q[ACC_W-1:0];
        state_d = S_DOT3;
      end
      S_DOT3: begin
        sd_start     = 1'b1;
        sd_cmd.op    = OP_DIV;
        sd_cmd.bits  = '0;
        sd_cmd.rem   = RDIV_REM0;
        sd_cmd.den   = SD_DEN_W'(dden);
        sd_cmd.count = RDIV_STEPS;
        state_d      = S_RDIV;
      end
      S_RDIV: begin
        if (sd_done) begin
          sd_start     = 1'b1;
          sd_cmd.op    = OP_SQRT;
          sd_cmd.bits  = SD_BITS_W'(sd_res);
          sd_cmd.count = SQRT_STEPS;
          state_d      = S_RSQ;
        end
      end
      S_RSQ: begin
        if (sd_done) begin
          ratio_d = (sd_res > SD_RES_W'(RATIO_CAP)) ? RAT_W'(RATIO_CAP)
                                                   : sd_res[RAT_W-1:0];
          state_d = S_E1;
        end
      end
      S_E1: state_d = S_E2;
      S_E2: state_d = S_E3;
      S_E3: begin
        ox_d    = rnd_ofs(mul_q);
        state_d = S_E4;
      end
      S_E4: state_d = S_E5;
      S_E5: begin
        oy_d    = rnd_ofs(mul_q);
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (emit_rdy) begin
          emit_load = 1'b1;
          if (last_q) begin
            seen_d  = 2'd0;
            state_d = S_IDLE;
          end else if (fin_q) begin
            nx_d    = -d2y_q;
            ny_d    = d2x_q;
            ratio_d = RAT_W'(DIR_ONE);
            bx_d    = px_q;
            by_d    = py_q;
            last_d  = 1'b1;
            state_d = S_E1;
          end else begin
            held_x_d = px_q;
            held_y_d = py_q;
            d1x_d    = d2x_q;
            d1y_d    = d2y_q;
            seen_d   = 2'd2;
            state_d  = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= RET_D2;
      seen_q  <= 2'd0;
      thick_q <= THICK_W'(256);
      color_q <= '1;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      seen_q  <= seen_d;
      thick_q <= thick_d;
      color_q <= color_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    fin_q    <= fin_d;
    held_x_q <= held_x_d;
    held_y_q <= held_y_d;
    bx_q     <= bx_d;
    by_q     <= by_d;
    last_q   <= last_d;
    d1x_q    <= d1x_d;
    d1y_q    <= d1y_d;
    d2x_q    <= d2x_d;
    d2y_q    <= d2y_d;
    ux_q     <= ux_d;
    uy_q     <= uy_d;
    nx_q     <= nx_d;
    ny_q     <= ny_d;
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    len_q    <= len_d;
    qx_q     <= qx_d;
    acc_q    <= acc_d;
    ratio_q  <= ratio_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    mul_q    <= mul_a * mul_b;
  end

  pms_sqdiv u_sqdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sd_start),
    .cmd_i   (sd_cmd),
    .done_o  (sd_done),
    .res_o   (sd_res)
  );

  assign emit_pair = '{px: bx_q, py: by_q, ox: ox_q, oy: oy_q, last: last_q};

  pms_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (emit_load),
    .pair_i       (emit_pair),
    .color_i      (color_q),
    .rdy_o        (emit_rdy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .left_x_o     (left_x_o),
    .left_y_o     (left_y_o),
    .right_x_o    (right_x_o),
    .right_y_o    (right_y_o),
    .pair_color_o (pair_color_o),
    .clipped_o    (clipped_o),
    .strip_end_o  (strip_end_o)
  );

  // The root/divide unit only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sd_done |-> (state_q == S_ROOT || state_q == S_DIVX || state_q == S_DIVY ||
                 state_q == S_RDIV || state_q == S_RSQ))
    else $error("root/divide result arrived outside a wait state");

  // A first point is absorbed without leaving idle.
  a_first_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && seen_q == 2'd0) |=> state_q == S_IDLE)
    else $error("first point started a computation");

  // After the final pair of a strip the point count starts over.
  a_strip_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && last_q) |=> (seen_q == 2'd0 && state_q == S_IDLE))
    else $error("point count not cleared after strip end");

  // A normalized component never exceeds the quotient width.
  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sd_done && (state_q == S_DIVX || state_q == S_DIVY)) |->
      sd_res[SD_RES_W-1:Q_W] == '0)
    else $error("unit vector quotient overflow");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Polyline miter stroker testbench
// Drives directed polylines and polylines of random length and shape (these
// with random gaps) through the stroker under output stalls, predicts every
// left/right vertex pair in fixed point and compares each whole pair in order.
// ----------------------------------------------------------------------------
class stroke_scoreboard;
  typedef struct packed {
    logic signed [23:0] lx, ly, rx, ry;
    logic [31:0]        color;
    logic               clip, last;
  } vertex_pair_t;

  vertex_pair_t       pending[$];
  logic signed [23:0] older_x, older_y, held_x, held_y;
  int unsigned        seen;
  logic [15:0]        thickness;
  logic [31:0]        color;
  int                 mismatches;

  function new();
    older_x = 0; older_y = 0; held_x = 0; held_y = 0; seen = 0;
    thickness = 16'd256; color = 32'hFFFF_FFFF; mismatches = 0;
  endfunction

  function automatic longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic void unit_dir(longint vx, longint vy, output longint ux,
                                   output longint uy);
    longint unsigned ax, ay, m, l, qx, qy;
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    m = ax > ay ? ax : ay;
    if (m == 0) begin
      ux = 0; uy = 0;
      return;
    end
    while (m >= (64'd1 << 21)) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 20)) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    l = root((ax * ax + ay * ay) << 20);
    qx = ((ax << 26) + l / 2) / l;
    qy = ((ay << 26) + l / 2) / l;
    ux = vx < 0 ? -longint'(qx) : longint'(qx);
    uy = vy < 0 ? -longint'(qy) : longint'(qy);
  endfunction

  function automatic logic signed [23:0] clamp(longint v, inout logic clip);
    if (v > 8388607) begin
      clip = 1'b1; return 24'sh7FFFFF;
    end
    if (v < -8388608) begin
      clip = 1'b1; return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic void add_pair(longint px, longint py, longint nx, longint ny,
                                   longint ratio, logic last);
    vertex_pair_t p;
    longint       ox, oy;
    logic         clip;
    clip = 1'b0;
    ox = round_shift(nx * ratio * longint'(thickness), 33);
    oy = round_shift(ny * ratio * longint'(thickness), 33);
    p.lx = clamp(px - ox, clip);
    p.ly = clamp(py - oy, clip);
    p.rx = clamp(px + ox, clip);
    p.ry = clamp(py + oy, clip);
    p.color = color;
    p.clip = clip;
    p.last = last;
    pending = {pending, p};
  endfunction

  function automatic void note_point(logic signed [23:0] x, logic signed [23:0] y,
                                     logic fin);
    longint px, py, d1x, d1y, d2x, d2y, nx, ny, dot, ratio;
    px = x; py = y;
    if (seen == 0) begin
      if (!fin) begin
        held_x = x; held_y = y; seen = 1;
      end
      return;
    end
    unit_dir(px - held_x, py - held_y, d2x, d2y);
    if (seen == 1) begin
      add_pair(held_x, held_y, -d2y, d2x, 65536, 1'b0);
    end else begin
      unit_dir(longint'(held_x) - older_x, longint'(held_y) - older_y, d1x, d1y);
      unit_dir(-(d1y + d2y), d1x + d2x, nx, ny);
      if (nx == 0 && ny == 0) begin
        nx = -d1y; ny = d1x;
      end
      dot = round_shift(d1x * d2x + d1y * d2y, 16);
      if (dot > 64881) dot = 64881;
      if (dot < -64881) dot = -64881;
      ratio = root((64'd1 << 49) / longint'(65536 + dot));
      if (ratio > 163840) ratio = 163840;
      add_pair(held_x, held_y, nx, ny, ratio, 1'b0);
    end
    if (fin) begin
      add_pair(px, py, -d2y, d2x, 65536, 1'b1);
      seen = 0;
    end else begin
      older_x = held_x; older_y = held_y;
      held_x = x; held_y = y;
      seen = 2;
    end
  endfunction

  function automatic void check_pair(vertex_pair_t got);
    vertex_pair_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected pair %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("pair mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module tb_top;
  import pms_pkg::*;

  logic                      clk_i = 0;
  logic                      rst_ni = 0;
  logic                      cfg_wr_en_i = 0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i = REG_THICKNESS;
  logic [CFG_DATA_W-1:0]     cfg_wdata_i = 0;
  logic                      in_valid_i = 0;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] point_x_i = 0;
  logic signed [COORD_W-1:0] point_y_i = 0;
  logic                      final_point_i = 0;
  logic                      out_valid_o;
  logic                      out_stall_i = 0;
  logic signed [COORD_W-1:0] left_x_o, left_y_o, right_x_o, right_y_o;
  logic [COLOR_W-1:0]        pair_color_o;
  logic                      clipped_o, strip_end_o;

  stroke_scoreboard board = new();
  int                 hold_off = 0;

  polyline_miter_stroker dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 9) == 0 ? $urandom_range(20, 300) : $urandom_range(0, 3);
  endfunction

  // Valid stays high after a transfer until the next point or an idle gap.
  task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, logic fin,
                            bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1;
    point_x_i <= x;
    point_y_i <= y;
    final_point_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    board.note_point(x, y, fin);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_wr_en_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_wr_en_i <= 0;
    if (idx == REG_THICKNESS) board.thickness = val[15:0];
    else board.color = val;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  function automatic logic signed [23:0] rand_coord(logic signed [23:0] base);
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return base;
      2: return base + $signed(24'($urandom_range(0, 8)) - 24'sd4);
      default: return base + $signed(24'($urandom_range(0, 65535)) - 24'sd32768);
    endcase
  endfunction

  // Output side: random stalls, plus one long hold-off requested by the sender.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1;
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_pair('{left_x_o, left_y_o, right_x_o, right_y_o, pair_color_o,
                         clipped_o, strip_end_o});
  end

  initial begin
    int                 n, len;
    logic signed [23:0] x, y;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;

    // Directed: single point, extremes, repeated points, reversal, saturation.
    send_point(24'sd100, 24'sd100, 1'b1, 1'b0);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 1'b0);
    send_point(24'sh800000, 24'sh800000, 1'b0, 1'b0);
    send_point(24'sh7FFFFF, 24'sh800000, 1'b1, 1'b0);
    send_point(24'sd0, 24'sd0, 1'b0, 1'b0);
    send_point(24'sd0, 24'sd0, 1'b0, 1'b0);
    send_point(24'sd0, 24'sd0, 1'b1, 1'b0);
    send_point(24'sd0, 24'sd0, 1'b0, 1'b0);
    send_point(24'sd256, 24'sd0, 1'b0, 1'b0);
    send_point(24'sd0, 24'sd0, 1'b0, 1'b0);
    send_point(24'sd256, 24'sd256, 1'b0, 1'b0);
    send_point(24'sd512, 24'sd0, 1'b1, 1'b0);
    send_point(24'sd10, 24'sd10, 1'b0, 1'b0);
    send_point(24'sd11, 24'sd10, 1'b1, 1'b0);
    drain();
    write_reg(REG_THICKNESS, 32'h0000_FFFF);
    write_reg(REG_COLOR, 32'h0000_0000);
    send_point(24'sh7FFF00, 24'sd0, 1'b0, 1'b0);
    send_point(24'sh7FFFFF, 24'sd300, 1'b0, 1'b0);
    send_point(24'sh7FFF00, 24'sd600, 1'b1, 1'b0);
    send_point(-24'sd100, 24'sd0, 1'b0, 1'b0);
    send_point(24'sd0, 24'sd50, 1'b0, 1'b0);
    send_point(24'sd100, 24'sd0, 1'b1, 1'b0);
    drain();
    write_reg(REG_THICKNESS, 32'hFFFF_0000);

    // Random polylines; each phase ends with a new register setting.
    n = 0;
    for (int phase = 0; phase < 6; phase++) begin
      while (n < (phase + 1) * 270) begin
        len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 6);
        x = 24'($urandom);
        y = 24'($urandom);
        if (phase == 2 && n == 2 * 270 + 10) hold_off = 3000;
        for (int i = 0; i < len; i++) begin
          send_point(x, y, i == len - 1, 1'b1);
          x = rand_coord(x);
          y = rand_coord(y);
          n++;
        end
      end
      drain();
      case (phase)
        0: write_reg(REG_THICKNESS, 32'd0);
        1: write_reg(REG_THICKNESS, 32'd1);
        2: write_reg(REG_COLOR, 32'hFFFF_FFFF);
        default: begin
          write_reg(REG_THICKNESS, $urandom);
          write_reg(REG_COLOR, $urandom);
        end
      endcase
    end
    drain();
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/pms_pkg.sv
hw/rtl/pms_sqdiv.sv
hw/rtl/pms_emit.sv
hw/rtl/polyline_miter_stroker.sv
sim/tb_top.sv
